// File: src/spq_pkg.sv
`default_nettype none

package spq_pkg;

    // Number of slots in the queue
    localparam int DEPTH = 16;
    // Live-entry counter holds 0 .. DEPTH
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam int VAL_W = 32;
    localparam int PRI_W = 8;
    localparam int OCC_W = 5;

    typedef enum logic {
        REQ_ENQ = 1'b0,
        REQ_DEQ = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        t_req_type                 req_type;
        logic signed [VAL_W-1:0]   item_value;
        logic        [PRI_W-1:0]   item_priority;
    } t_req;

    typedef struct packed {
        t_status                   status;
        logic signed [VAL_W-1:0]   out_value;
        logic        [OCC_W-1:0]   occupancy;
    } t_rsp;

    // Contents of one queue slot
    typedef struct packed {
        logic signed [VAL_W-1:0]   value;
        logic        [PRI_W-1:0]   prio;
    } t_slot;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic                      enq;
        logic                      deq;
        t_slot                     fresh;
    } t_cell_cmd;

endpackage

`default_nettype wire

// File: src/spq_cell.sv
`default_nettype none

module spq_cell
    import spq_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_cmd i_cmd,
    input  wire logic      i_live,
    input  wire logic      i_prev_stay,
    input  wire t_slot     i_prev_slot,
    input  wire t_slot     i_next_slot,
    output t_slot          o_slot,
    output logic           o_stay
);

    t_slot r_slot;
    t_slot n_slot;

    // Entry stays ahead of a new item when it is live and not lower priority
    assign o_stay = i_live && (r_slot.prio >= i_cmd.fresh.prio);
    assign o_slot = r_slot;

    always_comb begin
        n_slot = r_slot;
        if (i_cmd.enq) begin
            if (!o_stay) begin
                // first non-staying cell takes the new item, the rest shift back
                n_slot = i_prev_stay ? i_cmd.fresh : i_prev_slot;
            end
        end else if (i_cmd.deq) begin
            n_slot = i_next_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot <= n_slot;
    end

endmodule

`default_nettype wire

// File: src/sorted_priority_queue_unit.sv
// Sorted priority queue: a row of DEPTH slot cells, head in cell 0.
// Result: strobed on o_done in the cycle after the item is accepted.
// Throughput: one item per cycle; every cell compares and shifts in the same
// cycle, so busy stays low and the row never stalls. The receiver cannot stall.
// Reset (i_rst_n, synchronous, active low) empties the queue and drops the
// strobe; slot contents are left as they are and read only when live.
`default_nettype none

module sorted_priority_queue_unit
    import spq_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_done,
    output t_rsp      o_rsp
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_done;
    t_rsp             r_rsp;
    t_rsp             n_rsp;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    logic             enq_ok;
    logic             deq_ok;
    t_cell_cmd        cmd;

    t_slot            slots  [DEPTH];
    logic             stay   [DEPTH];
    logic             live   [DEPTH];

    // Row never stalls: every request is taken as soon as it is offered
    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign is_full  = (r_count >= CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);
    assign enq_ok   = accept && (i_req.req_type == REQ_ENQ) && !is_full;
    assign deq_ok   = accept && (i_req.req_type == REQ_DEQ) && !is_empty;

    assign cmd.enq        = enq_ok;
    assign cmd.deq        = deq_ok;
    assign cmd.fresh.value = i_req.item_value;
    assign cmd.fresh.prio  = i_req.item_priority;

    // Cell row: each cell sees its left neighbor (for insertion shift)
    // and its right neighbor (for dequeue shift).
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        t_slot prev_slot;
        t_slot next_slot;
        logic  prev_stay;

        // slots 0 .. count-1 hold live entries
        assign live[gi] = (CNT_W'(gi) < r_count);

        if (gi == 0) begin : g_head
            assign prev_stay = 1'b1;
            assign prev_slot = cmd.fresh;
        end else begin : g_body
            assign prev_stay = stay[gi-1];
            assign prev_slot = slots[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            // tail goes dead on dequeue; keep its contents
            assign next_slot = slots[gi];
        end else begin : g_inner
            assign next_slot = slots[gi+1];
        end

        spq_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (cmd),
            .i_live      (live[gi]),
            .i_prev_stay (prev_stay),
            .i_prev_slot (prev_slot),
            .i_next_slot (next_slot),
            .o_slot      (slots[gi]),
            .o_stay      (stay[gi])
        );
    end

    // Live-entry count
    always_comb begin
        n_count = r_count;
        if (enq_ok) begin
            n_count = r_count + CNT_W'(1);
        end else if (deq_ok) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Result for the accepted item; occupancy is the count after it, mod 32
    always_comb begin
        n_rsp.status    = ST_DONE;
        n_rsp.out_value = '0;
        n_rsp.occupancy = OCC_W'(n_count);
        unique case (i_req.req_type)
            REQ_ENQ: begin
                if (is_full) begin
                    n_rsp.status = ST_FULL;
                end
            end
            REQ_DEQ: begin
                if (is_empty) begin
                    n_rsp.status = ST_EMPTY;
                end else begin
                    n_rsp.out_value = slots[0].value;
                end
            end
            default: begin
                n_rsp.status = ST_DONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= accept;
        end
    end

    // Result payload, meaningful only with the strobe
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

`ifndef SYNTHESIS
    // Count never exceeds the number of slots
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("live count above depth");

    // Accepted enqueue into a non-full queue grows the count by one
    a_enq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        enq_ok |=> (r_count == $past(r_count) + CNT_W'(1)))
        else $error("enqueue did not grow count");

    // Exactly one result per accepted item, strobed in the next cycle
    a_one_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("accepted item produced no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_done)
        else $error("result without accepted item");

    // Live entries stay sorted, highest priority at the head
    for (genvar gj = 1; gj < DEPTH; gj++) begin : g_sorted
        a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            live[gj] |-> (slots[gj-1].prio >= slots[gj].prio))
            else $error("queue order broken");
    end
`endif

endmodule

`default_nettype wire
